// File: design/rc4_stream_cipher_unit_assert.svh
// Assertion macros for the RC4 stream cipher unit.
`ifndef RC4_STREAM_CIPHER_UNIT_ASSERT_SVH
`define RC4_STREAM_CIPHER_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
// Same-cycle implication, sampled on the rising clock edge.
`define RC4_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("rc4 assertion failed");
// Next-cycle implication, sampled on the rising clock edge.
`define RC4_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("rc4 assertion failed");
`else
`define RC4_ASSERT_NOW(label, ante, cons)
`define RC4_ASSERT_NEXT(label, ante, cons)
`endif
`endif

// File: design/rc4_pkg.sv
// Shared constants, types and codes for the RC4 stream cipher unit.
package rc4_pkg;

   localparam int BYTE_W     = 8;
   localparam int SBOX_DEPTH = 256;
   localparam int SBOX_AW    = $clog2(SBOX_DEPTH);
   localparam int KEY_DEPTH  = 256;
   localparam int KEY_AW     = (KEY_DEPTH > 1) ? $clog2(KEY_DEPTH) : 1;
   localparam int KEY_CW     = $clog2(KEY_DEPTH + 1);

   localparam logic [SBOX_AW-1:0] LAST_STEP = SBOX_AW'(SBOX_DEPTH - 1);

   // Operation codes of an input transaction
   localparam logic OP_KEY  = 1'b0;
   localparam logic OP_DATA = 1'b1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_D1,
      ST_D2,
      ST_FIN,
      ST_K0,
      ST_K1,
      ST_K2
   } state_type;

   // One write into the permutation memory
   typedef struct packed {
      logic                we;
      logic [SBOX_AW-1:0]  addr;
      logic [BYTE_W-1:0]   data;
   } perm_wr_type;

   // Key buffer controls
   typedef struct packed {
      logic append;
      logic restart;
      logic advance;
   } key_ctl_type;

endpackage

// File: design/rc4_ram.sv
// Generic single-write, single-read RAM with registered, write-first read.
module rc4_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                                      clock,
   input  logic                                      we,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
   input  logic [WIDTH-1:0]                          wdata,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
   output logic [WIDTH-1:0]                          rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // Write port and registered read; a same-address write is seen at once
   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (we && (waddr == raddr)) begin
         rdata_ff <= wdata;
      end else begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

// File: design/rc4_key_buf.sv
// Key byte buffer: append with saturation, and cyclic read-out for the key schedule.
module rc4_key_buf (
   input  logic                        clock,
   input  logic                        reset,
   input  rc4_pkg::key_ctl_type        ctl,
   input  logic [rc4_pkg::BYTE_W-1:0]  key_byte,
   output logic [rc4_pkg::BYTE_W-1:0]  key_q
);
   import rc4_pkg::*;

   logic [KEY_CW-1:0] count_ff, count_in;
   logic [KEY_CW-1:0] len_ff, len_in;
   logic [KEY_AW-1:0] ptr_ff, ptr_in;
   logic              room;
   logic [KEY_CW-1:0] count_after;

   assign room        = (count_ff < KEY_CW'(KEY_DEPTH));
   assign count_after = (ctl.append && room) ? count_ff + KEY_CW'(1) : count_ff;

   // Count, key length and read pointer
   always_comb begin
      count_in = count_after;
      len_in   = len_ff;
      ptr_in   = ptr_ff;
      if (ctl.restart) begin
         len_in   = count_after;
         count_in = '0;
         ptr_in   = '0;
      end else if (ctl.advance) begin
         if (KEY_CW'(ptr_ff) + KEY_CW'(1) == len_ff) begin
            ptr_in = '0;
         end else begin
            ptr_in = ptr_ff + KEY_AW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         ptr_ff   <= '0;
      end else begin
         count_ff <= count_in;
         ptr_ff   <= ptr_in;
      end
      len_ff <= len_in;
   end

   rc4_ram #(
      .WIDTH (BYTE_W),
      .DEPTH (KEY_DEPTH)
   ) u_key_ram (
      .clock (clock),
      .we    (ctl.append && room),
      .waddr (count_ff[KEY_AW-1:0]),
      .wdata (key_byte),
      .raddr (ptr_ff),
      .rdata (key_q)
   );

endmodule

// File: design/rc4_perm_store.sv
// Permutation memory with per-entry valid bits; an unwritten entry reads as its index.
module rc4_perm_store (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         clear_all,
   input  rc4_pkg::perm_wr_type         wr,
   input  logic [rc4_pkg::SBOX_AW-1:0]  raddr,
   output logic [rc4_pkg::BYTE_W-1:0]   rdata
);
   import rc4_pkg::*;

   logic [SBOX_DEPTH-1:0] valid_ff, valid_in;
   logic                  rvld_ff, rvld_in;
   logic [SBOX_AW-1:0]    raddr_ff;
   logic [BYTE_W-1:0]     ram_q;

   // Valid bits: clear restores the identity of every entry, ahead of any write
   always_comb begin
      valid_in = valid_ff;
      if (clear_all) begin
         valid_in = '0;
      end else if (wr.we) begin
         valid_in[wr.addr] = 1'b1;
      end
      rvld_in = valid_ff[raddr] || (wr.we && (wr.addr == raddr));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         rvld_ff  <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         rvld_ff  <= rvld_in;
      end
      raddr_ff <= raddr;
   end

   rc4_ram #(
      .WIDTH (BYTE_W),
      .DEPTH (SBOX_DEPTH)
   ) u_perm_ram (
      .clock (clock),
      .we    (wr.we),
      .waddr (wr.addr),
      .wdata (wr.data),
      .raddr (raddr),
      .rdata (ram_q)
   );

   // Unwritten entries hold their own index
   assign rdata = rvld_ff ? ram_q : BYTE_W'(raddr_ff);

endmodule

// File: design/rc4_stream_cipher_unit.sv
// RC4 stream cipher unit: key loading, key schedule and keystream XOR.
// Data transaction: states D1, D2 and FIN, then the result is registered on rsp; a new
// data byte is taken only from FIN on, set by the read-swap-read chain through the single
// read port of the permutation memory. A final key byte adds the key schedule: 256 steps.
// Reset clears the indices, the key count and the permutation valid bits, so the
// permutation reads as the identity in the first cycle after reset; no clearing pass.
module rc4_stream_cipher_unit (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic       req_operation,
   input  logic [7:0] req_key_byte,
   input  logic       req_key_last,
   input  logic [7:0] req_data_byte,
   input  logic       req_data_last,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_out_byte,
   output logic       rsp_out_last
);
   import rc4_pkg::*;

   state_type          state_ff, state_in;
   logic [SBOX_AW-1:0] i_ff, i_in;
   logic [SBOX_AW-1:0] j_ff, j_in;
   logic [BYTE_W-1:0]  si_ff, si_in;
   logic [SBOX_AW-1:0] t_ff, t_in;
   logic [SBOX_AW-1:0] k_ff, k_in;
   logic [BYTE_W-1:0]  acc_ff, acc_in;
   logic [BYTE_W-1:0]  sk_ff, sk_in;
   logic [BYTE_W-1:0]  dbyte_ff, dbyte_in;
   logic               dlast_ff, dlast_in;
   perm_wr_type        pw_ff, pw_in;

   logic               rsp_valid_ff, rsp_valid_in;
   logic [BYTE_W-1:0]  rsp_byte_ff, rsp_byte_in;
   logic               rsp_last_ff, rsp_last_in;
   logic               skid_valid_ff, skid_valid_in;
   logic [BYTE_W-1:0]  skid_byte_ff, skid_byte_in;
   logic               skid_last_ff, skid_last_in;

   perm_wr_type        wr;
   logic [SBOX_AW-1:0] rd_addr;
   logic [BYTE_W-1:0]  rd;
   logic               clear_all;
   key_ctl_type        key_ctl;
   logic [BYTE_W-1:0]  key_q;
   logic [BYTE_W-1:0]  ks;
   logic               res_valid;
   logic [BYTE_W-1:0]  res_byte;
   logic               out_free;
   logic               can_take;
   logic               req_accept;

   // Handshake on both sides
   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign can_take   = ((state_ff == ST_IDLE) || ((state_ff == ST_FIN) && out_free))
                       && !skid_valid_ff;
   assign req_stall  = !can_take;
   assign req_accept = req_valid && can_take;

   // S[j] is still pending when the keystream read returns
   assign ks       = (t_ff == j_ff) ? si_ff : rd;
   assign res_byte = dbyte_ff ^ ks;

   // Sequencer: next state and memory accesses
   always_comb begin
      state_in  = state_ff;
      i_in      = i_ff;
      j_in      = j_ff;
      si_in     = si_ff;
      t_in      = t_ff;
      k_in      = k_ff;
      acc_in    = acc_ff;
      sk_in     = sk_ff;
      dbyte_in  = dbyte_ff;
      dlast_in  = dlast_ff;
      pw_in     = '0;
      wr        = pw_ff;
      rd_addr   = '0;
      key_ctl   = '0;
      clear_all = 1'b0;
      res_valid = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            state_in = ST_IDLE;
         end
         ST_D1: begin
            si_in    = rd;
            j_in     = j_ff + rd;
            rd_addr  = j_ff + rd;
            state_in = ST_D2;
         end
         ST_D2: begin
            wr       = '{we: 1'b1, addr: i_ff, data: rd};
            pw_in    = '{we: 1'b1, addr: j_ff, data: si_ff};
            t_in     = si_ff + rd;
            rd_addr  = si_ff + rd;
            state_in = ST_FIN;
         end
         ST_FIN: begin
            res_valid = 1'b1;
            state_in  = ST_IDLE;
         end
         ST_K0: begin
            rd_addr  = k_ff;
            state_in = ST_K1;
         end
         ST_K1: begin
            sk_in          = rd;
            acc_in         = acc_ff + rd + key_q;
            rd_addr        = acc_ff + rd + key_q;
            key_ctl.advance = 1'b1;
            state_in       = ST_K2;
         end
         ST_K2: begin
            wr    = '{we: 1'b1, addr: k_ff, data: rd};
            pw_in = '{we: 1'b1, addr: acc_ff, data: sk_ff};
            k_in  = k_ff + SBOX_AW'(1);
            if (k_ff == LAST_STEP) begin
               state_in = ST_IDLE;
            end else begin
               state_in = ST_K0;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // New transaction
      if (req_accept) begin
         if (req_operation == OP_DATA) begin
            i_in     = i_ff + SBOX_AW'(1);
            rd_addr  = i_ff + SBOX_AW'(1);
            dbyte_in = req_data_byte;
            dlast_in = req_data_last;
            state_in = ST_D1;
         end else begin
            key_ctl.append = 1'b1;
            if (req_key_last) begin
               key_ctl.restart = 1'b1;
               clear_all       = 1'b1;
               i_in            = '0;
               j_in            = '0;
               k_in            = '0;
               acc_in          = '0;
               state_in        = ST_K0;
            end
         end
      end
   end

   // Output register with one skid entry
   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      rsp_byte_in   = rsp_byte_ff;
      rsp_last_in   = rsp_last_ff;
      skid_valid_in = skid_valid_ff;
      skid_byte_in  = skid_byte_ff;
      skid_last_in  = skid_last_ff;
      if (skid_valid_ff && out_free) begin
         rsp_valid_in  = 1'b1;
         rsp_byte_in   = skid_byte_ff;
         rsp_last_in   = skid_last_ff;
         skid_valid_in = 1'b0;
      end else if (res_valid && out_free) begin
         rsp_valid_in = 1'b1;
         rsp_byte_in  = res_byte;
         rsp_last_in  = dlast_ff;
      end else if (res_valid) begin
         skid_valid_in = 1'b1;
         skid_byte_in  = res_byte;
         skid_last_in  = dlast_ff;
      end else if (out_free) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         i_ff          <= '0;
         j_ff          <= '0;
         pw_ff         <= '0;
         rsp_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         i_ff          <= i_in;
         j_ff          <= j_in;
         pw_ff         <= pw_in;
         rsp_valid_ff  <= rsp_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      si_ff        <= si_in;
      t_ff         <= t_in;
      k_ff         <= k_in;
      acc_ff       <= acc_in;
      sk_ff        <= sk_in;
      dbyte_ff     <= dbyte_in;
      dlast_ff     <= dlast_in;
      rsp_byte_ff  <= rsp_byte_in;
      rsp_last_ff  <= rsp_last_in;
      skid_byte_ff <= skid_byte_in;
      skid_last_ff <= skid_last_in;
   end

   rc4_perm_store u_perm_store (
      .clock     (clock),
      .reset     (reset),
      .clear_all (clear_all),
      .wr        (wr),
      .raddr     (rd_addr),
      .rdata     (rd)
   );

   rc4_key_buf u_key_buf (
      .clock    (clock),
      .reset    (reset),
      .ctl      (key_ctl),
      .key_byte (req_key_byte),
      .key_q    (key_q)
   );

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_out_byte = rsp_byte_ff;
   assign rsp_out_last = rsp_last_ff;

   // Checks
`include "rc4_stream_cipher_unit_assert.svh"

   `RC4_ASSERT_NOW(a_skid_not_in_fin, skid_valid_ff, state_ff != ST_FIN)
   `RC4_ASSERT_NEXT(a_blocked_result_to_skid, (state_ff == ST_FIN) && rsp_valid_ff && rsp_stall, skid_valid_ff)
   `RC4_ASSERT_NOW(a_no_accept_in_schedule, (state_ff == ST_K0) || (state_ff == ST_K1) || (state_ff == ST_K2), req_stall)
   `RC4_ASSERT_NEXT(a_key_last_starts_schedule, req_accept && (req_operation == OP_KEY) && req_key_last, state_ff == ST_K0)

endmodule

// File: verif/tb_top.sv
// Self-checking testbench for rc4_stream_cipher_unit: directed rows, then random keyed messages.
`timescale 1ns / 1ps

module tb_top;
   import rc4_pkg::*;

   localparam int N_DIRECTED   = 21;
   localparam int N_RANDOM     = 1530;
   localparam int DRAIN_CYCLES = 1000;     // covers a full key schedule plus the result path
   localparam int CYCLE_LIMIT  = 1000000;

   // One expected output transaction
   typedef struct packed {
      logic [7:0] text;
      logic       last;
   } cipher_out_type;

   // One directed stimulus row; lit marks a hand-computed expected result
   typedef struct packed {
      logic       op;
      logic [7:0] kbyte;
      logic       klast;
      logic [7:0] dbyte;
      logic       dlast;
      logic       lit;
      logic [7:0] ebyte;
      logic       elast;
   } stim_row_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_stall;
   logic       req_operation = OP_KEY;
   logic [7:0] req_key_byte = 8'h00;
   logic       req_key_last = 1'b0;
   logic [7:0] req_data_byte = 8'h00;
   logic       req_data_last = 1'b0;
   logic       rsp_valid;
   logic       rsp_stall = 1'b0;
   logic [7:0] rsp_out_byte;
   logic       rsp_out_last;

   // Cipher state mirror
   logic [7:0] sbox [SBOX_DEPTH];
   logic [7:0] ks_i = 8'h00;
   logic [7:0] ks_j = 8'h00;
   logic [7:0] key_buf [KEY_DEPTH];
   logic [8:0] key_len = 9'd0;

   cipher_out_type pending_out [$];
   int             mismatch_count = 0;
   int             send_idle_pct = 0;
   int             rsp_stall_pct = 0;
   int             cycle_count = 0;

   // Directed rows: reset keystream, ignored fields, key "Key" on "Plaintext", one-byte key
   stim_row_type directed [N_DIRECTED] = '{
      '{OP_DATA, 8'h5A, 1'b1, 8'h00, 1'b0, 1'b1, 8'h02, 1'b0},
      '{OP_DATA, 8'hA5, 1'b0, 8'hFF, 1'b1, 1'b1, 8'hFA, 1'b1},
      '{OP_KEY,  8'h00, 1'b0, 8'hFF, 1'b1, 1'b0, 8'h00, 1'b0},
      '{OP_KEY,  8'hFF, 1'b1, 8'h00, 1'b0, 1'b0, 8'h00, 1'b0},
      '{OP_DATA, 8'hFF, 1'b1, 8'hA5, 1'b0, 1'b0, 8'h00, 1'b0},
      '{OP_DATA, 8'h00, 1'b0, 8'h5A, 1'b1, 1'b0, 8'h00, 1'b0},
      '{OP_KEY,  8'h4B, 1'b0, 8'h00, 1'b0, 1'b0, 8'h00, 1'b0},
      '{OP_KEY,  8'h65, 1'b0, 8'h00, 1'b0, 1'b0, 8'h00, 1'b0},
      '{OP_KEY,  8'h79, 1'b1, 8'h00, 1'b0, 1'b0, 8'h00, 1'b0},
      '{OP_DATA, 8'h00, 1'b0, 8'h50, 1'b0, 1'b1, 8'hBB, 1'b0},
      '{OP_DATA, 8'h00, 1'b0, 8'h6C, 1'b0, 1'b1, 8'hF3, 1'b0},
      '{OP_DATA, 8'h00, 1'b0, 8'h61, 1'b0, 1'b1, 8'h16, 1'b0},
      '{OP_DATA, 8'h00, 1'b0, 8'h69, 1'b0, 1'b1, 8'hE8, 1'b0},
      '{OP_DATA, 8'h00, 1'b0, 8'h6E, 1'b0, 1'b1, 8'hD9, 1'b0},
      '{OP_DATA, 8'h00, 1'b0, 8'h74, 1'b0, 1'b1, 8'h40, 1'b0},
      '{OP_DATA, 8'h00, 1'b0, 8'h65, 1'b0, 1'b1, 8'hAF, 1'b0},
      '{OP_DATA, 8'h00, 1'b0, 8'h78, 1'b0, 1'b1, 8'h0A, 1'b0},
      '{OP_DATA, 8'h00, 1'b0, 8'h74, 1'b1, 1'b1, 8'hD3, 1'b1},
      '{OP_KEY,  8'h80, 1'b1, 8'h00, 1'b0, 1'b0, 8'h00, 1'b0},
      '{OP_DATA, 8'h00, 1'b0, 8'h00, 1'b0, 1'b0, 8'h00, 1'b0},
      '{OP_DATA, 8'h00, 1'b0, 8'hFF, 1'b1, 1'b0, 8'h00, 1'b0}
   };

   rc4_stream_cipher_unit uut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_operation (req_operation),
      .req_key_byte  (req_key_byte),
      .req_key_last  (req_key_last),
      .req_data_byte (req_data_byte),
      .req_data_last (req_data_last),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_out_byte  (rsp_out_byte),
      .rsp_out_last  (rsp_out_last)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Key schedule over the bytes loaded so far, then clear indices and key count
   function automatic void rekey();
      logic [7:0] acc;
      logic [7:0] t;
      int         len;
      len = (key_len == 0) ? 1 : int'(key_len);
      for (int k = 0; k < SBOX_DEPTH; k++) sbox[k] = k[7:0];
      acc = 8'h00;
      for (int k = 0; k < SBOX_DEPTH; k++) begin
         acc = acc + sbox[k] + key_buf[k % len];
         t = sbox[k];
         sbox[k] = sbox[acc];
         sbox[acc] = t;
      end
      ks_i = 8'h00;
      ks_j = 8'h00;
      key_len = 9'd0;
   endfunction

   // One generator step: advance indices, swap, return the keystream byte
   function automatic logic [7:0] next_keystream();
      logic [7:0] t;
      logic [7:0] pos;
      ks_i = ks_i + 8'd1;
      ks_j = ks_j + sbox[ks_i];
      t = sbox[ks_i];
      sbox[ks_i] = sbox[ks_j];
      sbox[ks_j] = t;
      pos = sbox[ks_i] + sbox[ks_j];
      return sbox[pos];
   endfunction

   // Drive one request transaction, hold it until accepted, then update the mirror
   task automatic send_item(input logic op, input logic [7:0] kb, input logic kl,
                            input logic [7:0] db, input logic dl,
                            input logic use_lit = 1'b0, input logic [7:0] lit_text = 8'h00,
                            input logic lit_last = 1'b0);
      cipher_out_type want;
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_operation <= op;
      req_key_byte  <= kb;
      req_key_last  <= kl;
      req_data_byte <= db;
      req_data_last <= dl;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      if (op == OP_DATA) begin
         want.text = db ^ next_keystream();
         want.last = dl;
         if (use_lit) begin
            want.text = lit_text;
            want.last = lit_last;
         end
         pending_out.push_back(want);
      end else begin
         // key bytes past the buffer depth are dropped
         if (key_len < KEY_DEPTH) begin
            key_buf[key_len] = kb;
            key_len = key_len + 9'd1;
         end
         if (kl) rekey();
      end
   endtask

   // Hold the sender off until every expected result is back
   task automatic pause_until_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_out.size() != 0) @(posedge clock);
   endtask

   // Random keyed messages, data-only runs and noise, over four idling phases
   task automatic random_traffic(input int total);
      int sent;
      int phase;
      int last_phase;
      int len;
      int r;
      bit full_key_due;
      sent = 0;
      last_phase = 0;
      full_key_due = 1'b1;
      while (sent < total) begin
         phase = sent * 4 / total;
         if (phase != last_phase) begin
            pause_until_drained();
            case (phase)
               1: begin
                  send_idle_pct = 47;
                  rsp_stall_pct = 0;
               end
               2: begin
                  send_idle_pct = 0;
                  rsp_stall_pct = 47;
               end
               default: begin
                  send_idle_pct = 21;
                  rsp_stall_pct = 21;
               end
            endcase
            last_phase = phase;
         end
         r = $urandom_range(99);
         if (r < 75) begin
            // new key then a message; the first one overfills the key buffer
            r = $urandom_range(99);
            if (full_key_due) len = $urandom_range(270, 257);
            else if (r < 12) len = $urandom_range(64, 17);
            else len = $urandom_range(16, 1);
            full_key_due = 1'b0;
            for (int k = 1; k <= len; k++)
               send_item(OP_KEY, 8'($urandom_range(255)), k == len,
                         8'($urandom_range(255)), 1'($urandom_range(1)));
            sent += len;
            len = $urandom_range(40, 1);
            for (int k = 1; k <= len; k++)
               send_item(OP_DATA, 8'($urandom_range(255)), 1'($urandom_range(1)),
                         8'($urandom_range(255)), k == len);
            sent += len;
         end else if (r < 90) begin
            // message continuing the current keystream
            len = $urandom_range(12, 1);
            for (int k = 1; k <= len; k++)
               send_item(OP_DATA, 8'($urandom_range(255)), 1'($urandom_range(1)),
                         8'($urandom_range(255)), k == len);
            sent += len;
         end else begin
            // noise: a single transaction with every field random
            send_item(1'($urandom_range(1)), 8'($urandom_range(255)), 1'($urandom_range(1)),
                      8'($urandom_range(255)), 1'($urandom_range(1)));
            sent += 1;
         end
      end
   endtask

   task automatic flag_error(input string what, input cipher_out_type want);
      if (mismatch_count < 10)
         $display("%0t: %s: expected byte %02h last %0b, got byte %02h last %0b",
                  $time, what, want.text, want.last, rsp_out_byte, rsp_out_last);
      mismatch_count++;
   endtask

   // Result stall generator
   always @(posedge clock) begin
      if (reset) rsp_stall <= 1'b0;
      else rsp_stall <= ($urandom_range(99) < rsp_stall_pct);
   end

   // Result checker
   always @(posedge clock) begin
      cipher_out_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_out.size() == 0) begin
            want = '0;
            flag_error("result with nothing pending", want);
         end else begin
            want = pending_out.pop_front();
            if (rsp_out_byte !== want.text || rsp_out_last !== want.last)
               flag_error("result mismatch", want);
         end
      end
   end

   // Watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end
   end

   initial begin
      for (int k = 0; k < SBOX_DEPTH; k++) sbox[k] = k[7:0];
      for (int k = 0; k < KEY_DEPTH; k++) key_buf[k] = 8'h00;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      for (int n = 0; n < N_DIRECTED; n++)
         send_item(directed[n].op, directed[n].kbyte, directed[n].klast,
                   directed[n].dbyte, directed[n].dlast,
                   directed[n].lit, directed[n].ebyte, directed[n].elast);
      pause_until_drained();
      random_traffic(N_RANDOM);
      pause_until_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && pending_out.size() == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

endmodule
